@@ rtl/core/clcd_pkg.sv @@
package clcd_pkg;

    localparam int QUEUE_DEPTH = 3;
    localparam int TEXT_MAX    = 32;
    localparam int MEM_DEPTH   = QUEUE_DEPTH * TEXT_MAX;
    localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_W       = $clog2(TEXT_MAX + 1);
    localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [2:0] ACT_STEP   = 3'd0;
    localparam logic [2:0] ACT_TICK   = 3'd1;
    localparam logic [2:0] ACT_CLEAR  = 3'd2;
    localparam logic [2:0] ACT_MOVE   = 3'd3;
    localparam logic [2:0] ACT_LOAD   = 3'd4;
    localparam logic [2:0] ACT_COMMIT = 3'd5;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_MOVE  = 2'd1;
    localparam logic [1:0] KIND_TEXT  = 2'd2;

    localparam logic [1:0] BUS_NONE   = 2'd0;
    localparam logic [1:0] BUS_INSTR  = 2'd1;
    localparam logic [1:0] BUS_DATA   = 2'd2;
    localparam logic [1:0] BUS_STATUS = 2'd3;

    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_DDRAM   = 8'h80;
    localparam logic [7:0] ROW2_OFFSET = 8'h40;
    localparam logic [7:0] TICK_MAX    = 8'hFF;

    localparam logic REG_CLEAR_WAIT   = 1'b0;
    localparam logic REG_BUSY_TIMEOUT = 1'b1;

    localparam logic [7:0] CLEAR_WAIT_RST   = 8'd4;
    localparam logic [7:0] BUSY_TIMEOUT_RST = 8'd1;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_SETUP    = 3'd1,
        ST_POLL     = 3'd2,
        ST_CLR_SEND = 3'd3,
        ST_CLR_WAIT = 3'd4,
        ST_MOVE     = 3'd5,
        ST_TEXT     = 3'd6
    } t_seq_state;

    typedef struct packed {
        logic [2:0] action;
        logic       busy_flag;
        logic [5:0] column;
        logic       row;
        logic [7:0] text_char;
    } t_in;

    typedef struct packed {
        logic       accepted;
        logic       lcd_busy;
        logic [1:0] bus_cycle;
        logic [7:0] bus_byte;
    } t_out;

    typedef struct packed {
        logic valid;
        t_in  data;
    } t_in_stage;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] text_addr(input logic [SLOT_W-1:0] s,
                                                    input logic [LEN_W-1:0] p);
        return ADDR_W'(ADDR_W'(s) * ADDR_W'(TEXT_MAX) + ADDR_W'(p));
    endfunction

endpackage

@@ rtl/core/clcd_in_stage.sv @@
module clcd_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  clcd_pkg::t_in     i_data,
    input  logic              i_fire,
    output clcd_pkg::t_in_stage o_stage
);
    import clcd_pkg::*;

    logic r_valid;
    t_in  r_data;

    assign o_ready = !r_valid || i_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

endmodule

@@ rtl/core/clcd_engine.sv @@
module clcd_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_fire,
    input  clcd_pkg::t_in   i_data,
    output clcd_pkg::t_out  o_res
);
    import clcd_pkg::*;

    logic [7:0]        r_clr_wait;
    logic [7:0]        r_busy_to;

    t_seq_state        r_state, n_state;
    logic [1:0]        r_pkind, n_pkind;
    logic [5:0]        r_pcol, n_pcol;
    logic              r_prow, n_prow;
    logic [7:0]        r_tick, n_tick;
    logic [SLOT_W-1:0] r_wr, n_wr;
    logic [SLOT_W-1:0] r_rds, n_rds;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_send, n_send;
    logic [LEN_W-1:0]  r_pos, n_pos;
    logic              r_tip, n_tip;
    logic [LEN_W-1:0]  r_len [QUEUE_DEPTH];
    logic [LEN_W-1:0]  n_len [QUEUE_DEPTH];

    logic [1:0]        r_skind [QUEUE_DEPTH];
    logic [5:0]        r_scol  [QUEUE_DEPTH];
    logic              r_srow  [QUEUE_DEPTH];

    logic [7:0]        mem [MEM_DEPTH];
    logic [7:0]        r_rd_byte;

    logic              slot_we;
    logic [1:0]        slot_kind_d;
    logic [5:0]        slot_col_d;
    logic              slot_row_d;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic              wr_free;
    logic              acc;
    logic [1:0]        cyc;
    logic [7:0]        bus_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_wait <= CLEAR_WAIT_RST;
            r_busy_to  <= BUSY_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_CLEAR_WAIT) begin
                r_clr_wait <= i_cfg_data;
            end else begin
                r_busy_to <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pkind     = r_pkind;
        n_pcol      = r_pcol;
        n_prow      = r_prow;
        n_tick      = r_tick;
        n_wr        = r_wr;
        n_rds       = r_rds;
        n_cnt       = r_cnt;
        n_send      = r_send;
        n_pos       = r_pos;
        n_tip       = r_tip;
        n_len       = r_len;
        slot_we     = 1'b0;
        slot_kind_d = KIND_CLEAR;
        slot_col_d  = '0;
        slot_row_d  = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = text_addr(r_wr, r_len[r_wr]);
        acc         = 1'b0;
        cyc         = BUS_NONE;
        bus_byte    = '0;
        wr_free     = (r_cnt < CNT_W'(QUEUE_DEPTH)) && !(r_tip && r_send == r_wr);

        if (i_fire) begin
            case (i_data.action)
                ACT_STEP: begin
                    case (r_state)
                        ST_IDLE: begin
                            if (r_cnt != '0) begin
                                if (r_skind[r_rds] == KIND_MOVE) begin
                                    n_pkind = KIND_MOVE;
                                    n_pcol  = r_scol[r_rds];
                                    n_prow  = r_srow[r_rds];
                                end else if (r_skind[r_rds] == KIND_TEXT) begin
                                    n_pkind = KIND_TEXT;
                                    n_send  = r_rds;
                                    n_pos   = '0;
                                    n_tip   = 1'b1;
                                end else begin
                                    n_pkind = KIND_CLEAR;
                                end
                                n_rds   = next_slot(r_rds);
                                n_cnt   = r_cnt - CNT_W'(1);
                                n_state = ST_SETUP;
                            end
                        end
                        ST_SETUP: begin
                            n_tick  = '0;
                            n_state = ST_POLL;
                        end
                        ST_POLL: begin
                            cyc = BUS_STATUS;
                            if (r_tick >= r_busy_to || !i_data.busy_flag) begin
                                if (r_pkind == KIND_MOVE) begin
                                    n_state = ST_MOVE;
                                end else if (r_pkind == KIND_TEXT) begin
                                    n_state = ST_TEXT;
                                end else begin
                                    n_state = ST_CLR_SEND;
                                end
                            end
                        end
                        ST_CLR_SEND: begin
                            cyc      = BUS_INSTR;
                            bus_byte = CMD_CLEAR;
                            n_tick   = '0;
                            n_state  = ST_CLR_WAIT;
                        end
                        ST_CLR_WAIT: begin
                            if (r_tick >= r_clr_wait) begin
                                n_state = ST_IDLE;
                            end
                        end
                        ST_MOVE: begin
                            cyc      = BUS_INSTR;
                            bus_byte = CMD_DDRAM | {2'b00, r_pcol} |
                                       (r_prow ? ROW2_OFFSET : 8'h00);
                            n_tick   = '0;
                            n_state  = ST_IDLE;
                        end
                        ST_TEXT: begin
                            if (r_tick != '0) begin
                                if (r_pos < r_len[r_send] && r_pos < LEN_W'(TEXT_MAX)) begin
                                    cyc      = BUS_DATA;
                                    bus_byte = r_rd_byte;
                                    n_pos    = r_pos + LEN_W'(1);
                                    n_tick   = '0;
                                end else begin
                                    n_len[r_send] = '0;
                                    n_tip         = 1'b0;
                                    n_state       = ST_IDLE;
                                end
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
                ACT_TICK: begin
                    if (r_tick != TICK_MAX) begin
                        n_tick = r_tick + 8'd1;
                    end
                end
                ACT_CLEAR, ACT_MOVE, ACT_COMMIT: begin
                    if (wr_free) begin
                        slot_we = 1'b1;
                        if (i_data.action == ACT_MOVE) begin
                            slot_kind_d = KIND_MOVE;
                            slot_col_d  = i_data.column;
                            slot_row_d  = i_data.row;
                        end else if (i_data.action == ACT_COMMIT) begin
                            slot_kind_d = KIND_TEXT;
                        end
                        if (i_data.action != ACT_COMMIT) begin
                            n_len[r_wr] = '0;
                        end
                        n_wr  = next_slot(r_wr);
                        n_cnt = r_cnt + CNT_W'(1);
                        acc   = 1'b1;
                    end
                end
                ACT_LOAD: begin
                    if (wr_free && i_data.text_char != 8'h00 &&
                        r_len[r_wr] < LEN_W'(TEXT_MAX)) begin
                        mem_we      = 1'b1;
                        n_len[r_wr] = r_len[r_wr] + LEN_W'(1);
                        acc         = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        o_res.accepted  = acc;
        o_res.lcd_busy  = (n_state != ST_IDLE) || (n_cnt != '0);
        o_res.bus_cycle = cyc;
        o_res.bus_byte  = bus_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pkind <= KIND_CLEAR;
            r_pcol  <= '0;
            r_prow  <= 1'b0;
            r_tick  <= '0;
            r_wr    <= '0;
            r_rds   <= '0;
            r_cnt   <= '0;
            r_send  <= '0;
            r_pos   <= '0;
            r_tip   <= 1'b0;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_len[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pkind <= n_pkind;
            r_pcol  <= n_pcol;
            r_prow  <= n_prow;
            r_tick  <= n_tick;
            r_wr    <= n_wr;
            r_rds   <= n_rds;
            r_cnt   <= n_cnt;
            r_send  <= n_send;
            r_pos   <= n_pos;
            r_tip   <= n_tip;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_skind[r_wr] <= slot_kind_d;
            r_scol[r_wr]  <= slot_col_d;
            r_srow[r_wr]  <= slot_row_d;
        end
    end

    // read address follows the next send position so the byte is registered by the time that position is current
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= i_data.text_char;
        end
        r_rd_byte <= mem[text_addr(n_send, n_pos)];
    end

endmodule

@@ rtl/core/clcd_out_stage.sv @@
module clcd_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  clcd_pkg::t_out i_res,
    input  logic           i_ready,
    output logic           o_valid,
    output clcd_pkg::t_out o_data
);
    import clcd_pkg::*;

    logic r_valid;
    t_out r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_data <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/core/char_lcd_command_sequencer_core.sv @@
// Character LCD command sequencer.
// Input channel (i_in_valid/o_in_ready/i_in_data) carries one action per
// transaction: motor step, timer tick, queue clear, queue move, load a text
// character or commit text. Every input transaction yields exactly one
// result transaction on o_out_valid/i_out_ready/o_out_data, in order.
// The transaction is captured in an input register; when it fires, the
// sequencer state updates and the result is loaded into the output
// register together. Throughput is one transaction per clock while the
// receiver does not stall; the limit is the single state update per cycle
// and the text memory, written and read once per cycle, whose read is
// launched from the next send position so the byte is ready in time.
// When the receiver stalls, the output register holds its result and the
// input register takes one more transaction; further input waits on ready.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 clear wait ticks, 1 busy timeout ticks); write only while idle.
// Synchronous active-low reset empties both registers and the command
// queue and returns the sequencer to idle; no clearing pass is needed.
module char_lcd_command_sequencer_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  clcd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output clcd_pkg::t_out o_out_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [7:0]     i_cfg_data
);
    import clcd_pkg::*;

    t_in_stage w_stage;
    t_out      w_res;
    logic      w_fire;

    assign w_fire = w_stage.valid && (!o_out_valid || i_out_ready);

    clcd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .i_fire  (w_fire),
        .o_stage (w_stage)
    );

    clcd_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (w_fire),
        .i_data     (w_stage.data),
        .o_res      (w_res)
    );

    clcd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_res   (w_res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    a_no_byte_on_idle_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.bus_cycle == BUS_NONE ||
                        o_out_data.bus_cycle == BUS_STATUS) |-> o_out_data.bus_byte == 8'h00)
        else $error("bus byte nonzero without a write cycle");

    a_accept_no_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.accepted |-> o_out_data.bus_cycle == BUS_NONE)
        else $error("queue action produced a bus cycle");

    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.bus_cycle == BUS_DATA |-> o_out_data.bus_byte != 8'h00)
        else $error("zero character sent on data write");

    a_stalled_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stage.valid && o_out_valid && !i_out_ready |=> w_stage.valid)
        else $error("pending transaction dropped while output stalled");

endmodule

@@ bench/lcd_seq_checker.sv @@
module lcd_seq_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  clcd_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  clcd_pkg::t_out i_out_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [7:0]     i_cfg_data,
    output int             o_fail_count,
    output int             o_pending,
    output logic           o_seq_idle
);
    import clcd_pkg::*;

    logic [7:0]        clr_wait;
    logic [7:0]        busy_to;

    t_seq_state        seq_st;
    logic [1:0]        pend_kind;
    logic [5:0]        pend_col;
    logic              pend_row;
    logic [7:0]        ticks;
    logic [1:0]        s_kind [QUEUE_DEPTH];
    logic [5:0]        s_col  [QUEUE_DEPTH];
    logic              s_row  [QUEUE_DEPTH];
    logic [LEN_W-1:0]  s_len  [QUEUE_DEPTH];
    logic [7:0]        txt    [MEM_DEPTH];
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
    logic [SLOT_W-1:0] send_slot;
    logic [CNT_W-1:0]  q_count;
    logic [LEN_W-1:0]  txt_pos;
    logic              txt_active;

    t_out              lcd_resp_q[$];
    t_out              want;
    int                fails;

    function automatic void reset_sequencer_model();
        clr_wait   = CLEAR_WAIT_RST;
        busy_to    = BUSY_TIMEOUT_RST;
        seq_st     = ST_IDLE;
        pend_kind  = KIND_CLEAR;
        pend_col   = '0;
        pend_row   = 1'b0;
        ticks      = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            s_kind[i] = KIND_CLEAR;
            s_col[i]  = '0;
            s_row[i]  = 1'b0;
            s_len[i]  = '0;
        end
        for (int i = 0; i < MEM_DEPTH; i++) begin
            txt[i] = '0;
        end
        wr_slot    = '0;
        rd_slot    = '0;
        send_slot  = '0;
        q_count    = '0;
        txt_pos    = '0;
        txt_active = 1'b0;
    endfunction

    function automatic bit slot_open();
        return (int'(q_count) < QUEUE_DEPTH) && !(txt_active && send_slot == wr_slot);
    endfunction

    function automatic void push_command(input logic [1:0] kind, input logic [5:0] col,
                                         input logic row);
        s_kind[wr_slot] = kind;
        s_col[wr_slot]  = col;
        s_row[wr_slot]  = row;
        if (kind != KIND_TEXT) begin
            s_len[wr_slot] = '0;
        end
        wr_slot = SLOT_W'((int'(wr_slot) + 1) % QUEUE_DEPTH);
        q_count = q_count + 1'b1;
    endfunction

    function automatic void advance_motor(input logic busy, output logic [1:0] cyc,
                                          output logic [7:0] byt);
        cyc = BUS_NONE;
        byt = '0;
        case (seq_st)
            ST_IDLE: begin
                if (q_count != 0) begin
                    pend_kind = s_kind[rd_slot];
                    if (pend_kind == KIND_MOVE) begin
                        pend_col = s_col[rd_slot];
                        pend_row = s_row[rd_slot];
                    end else if (pend_kind == KIND_TEXT) begin
                        send_slot  = rd_slot;
                        txt_pos    = '0;
                        txt_active = 1'b1;
                    end else begin
                        pend_kind = KIND_CLEAR;
                    end
                    rd_slot = SLOT_W'((int'(rd_slot) + 1) % QUEUE_DEPTH);
                    q_count = q_count - 1'b1;
                    seq_st  = ST_SETUP;
                end
            end
            ST_SETUP: begin
                ticks  = '0;
                seq_st = ST_POLL;
            end
            ST_POLL: begin
                cyc = BUS_STATUS;
                if (ticks >= busy_to || !busy) begin
                    if (pend_kind == KIND_MOVE) begin
                        seq_st = ST_MOVE;
                    end else if (pend_kind == KIND_TEXT) begin
                        seq_st = ST_TEXT;
                    end else begin
                        seq_st = ST_CLR_SEND;
                    end
                end
            end
            ST_CLR_SEND: begin
                cyc    = BUS_INSTR;
                byt    = CMD_CLEAR;
                ticks  = '0;
                seq_st = ST_CLR_WAIT;
            end
            ST_CLR_WAIT: begin
                if (ticks >= clr_wait) begin
                    seq_st = ST_IDLE;
                end
            end
            ST_MOVE: begin
                cyc    = BUS_INSTR;
                byt    = CMD_DDRAM | {2'b00, pend_col} | (pend_row ? ROW2_OFFSET : 8'h00);
                ticks  = '0;
                seq_st = ST_IDLE;
            end
            ST_TEXT: begin
                // one character per step, only once a tick has elapsed
                if (ticks != 0) begin
                    if (txt_pos < s_len[send_slot] && txt_pos < LEN_W'(TEXT_MAX)) begin
                        cyc     = BUS_DATA;
                        byt     = txt[int'(send_slot) * TEXT_MAX + int'(txt_pos)];
                        txt_pos = txt_pos + 1'b1;
                        ticks   = '0;
                    end else begin
                        s_len[send_slot] = '0;
                        txt_active       = 1'b0;
                        seq_st           = ST_IDLE;
                    end
                end
            end
            default: seq_st = ST_IDLE;
        endcase
    endfunction

    function automatic t_out predict_lcd_response(input t_in tr);
        t_out       r;
        logic [1:0] cyc;
        logic [7:0] byt;
        r   = '0;
        cyc = BUS_NONE;
        byt = '0;
        case (tr.action)
            ACT_STEP: advance_motor(tr.busy_flag, cyc, byt);
            ACT_TICK: begin
                if (ticks < TICK_MAX) begin
                    ticks = ticks + 1'b1;
                end
            end
            ACT_CLEAR: begin
                if (slot_open()) begin
                    push_command(KIND_CLEAR, '0, 1'b0);
                    r.accepted = 1'b1;
                end
            end
            ACT_MOVE: begin
                if (slot_open()) begin
                    push_command(KIND_MOVE, tr.column, tr.row);
                    r.accepted = 1'b1;
                end
            end
            ACT_LOAD: begin
                if (slot_open() && tr.text_char != 0 && s_len[wr_slot] < LEN_W'(TEXT_MAX)) begin
                    txt[int'(wr_slot) * TEXT_MAX + int'(s_len[wr_slot])] = tr.text_char;
                    s_len[wr_slot] = s_len[wr_slot] + 1'b1;
                    r.accepted     = 1'b1;
                end
            end
            ACT_COMMIT: begin
                if (slot_open()) begin
                    push_command(KIND_TEXT, '0, 1'b0);
                    r.accepted = 1'b1;
                end
            end
            default: ;
        endcase
        r.lcd_busy  = (seq_st != ST_IDLE) || (q_count != 0);
        r.bus_cycle = cyc;
        r.bus_byte  = byt;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_sequencer_model();
            lcd_resp_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_CLEAR_WAIT) begin
                    clr_wait = i_cfg_data;
                end else begin
                    busy_to = i_cfg_data;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (lcd_resp_q.size() == 0) begin
                    $error("result transaction with nothing pending: %h", i_out_data);
                    fails++;
                end else begin
                    want = lcd_resp_q.pop_front();
                    check_field("accepted", 8'(want.accepted), 8'(i_out_data.accepted));
                    check_field("lcd_busy", 8'(want.lcd_busy), 8'(i_out_data.lcd_busy));
                    check_field("bus_cycle", 8'(want.bus_cycle), 8'(i_out_data.bus_cycle));
                    check_field("bus_byte", want.bus_byte, i_out_data.bus_byte);
                end
            end
            if (i_in_valid && i_in_ready) begin
                lcd_resp_q.push_back(predict_lcd_response(i_in_data));
            end
        end
        o_fail_count = fails;
        o_pending    = lcd_resp_q.size();
        o_seq_idle   = (seq_st == ST_IDLE) && (q_count == 0);
    end

endmodule

@@ bench/tb.sv @@
module tb;
    import clcd_pkg::*;

    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;
    localparam int LONG_HOLD        = 200;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PER_PHASE = 20;
    localparam int NUM_PHASES       = 5;
    localparam int SETTLE           = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in        i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out       o_out_data;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;

    int   fail_count;
    int   pending;
    logic seq_idle;
    int   items_sent;
    int   cycles;
    bit   no_gaps;
    int   hold_req;
    int   rx_idle_left;

    char_lcd_command_sequencer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    lcd_seq_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_seq_idle   (seq_idle)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic t_in mk_tr(input logic [2:0] act, input logic busy,
                                  input logic [5:0] col, input logic row,
                                  input logic [7:0] ch);
        t_in t;
        t.action    = act;
        t.busy_flag = busy;
        t.column    = col;
        t.row       = row;
        t.text_char = ch;
        return t;
    endfunction

    function automatic t_in rnd_tr(input logic [2:0] act);
        return mk_tr(act, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endfunction

    task automatic send_tr(input t_in tr, input int min_gap);
        int g;
        i_in_valid <= 1'b1;
        i_in_data  <= tr;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        g = pick_gap();
        if (g < min_gap) begin
            g = min_gap;
        end
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic step_tr(input logic busy, input int min_gap);
        t_in t;
        t = rnd_tr(ACT_STEP);
        t.busy_flag = busy;
        send_tr(t, min_gap);
    endtask

    // run the sequencer with ticks and non-busy steps until it is idle and empty
    task automatic drain_sequencer();
        int n;
        do begin
            n = $urandom_range(1, 3);
            repeat (n) send_tr(rnd_tr(ACT_TICK), 0);
            step_tr(1'b0, 1);
        end while (!seq_idle);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [7:0] wait_ticks, input logic [7:0] timeout_ticks);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_CLEAR_WAIT;
        i_cfg_data <= wait_ticks;
        @(posedge i_clk);
        i_cfg_idx  <= REG_BUSY_TIMEOUT;
        i_cfg_data <= timeout_ticks;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic queue_command();
        int  kind;
        int  len;
        int  r;
        t_in t;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            send_tr(rnd_tr(ACT_CLEAR), 0);
        end else if (kind < 5) begin
            send_tr(rnd_tr(ACT_MOVE), 0);
        end else begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(33, 35) : $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
                t = rnd_tr(ACT_LOAD);
                t.text_char = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
                send_tr(t, 0);
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
                send_tr(rnd_tr(ACT_CLEAR), 0);
            end else if (r == 1) begin
                send_tr(rnd_tr(ACT_MOVE), 0);
            end else begin
                send_tr(rnd_tr(ACT_COMMIT), 0);
            end
        end
    endtask

    task automatic run_sequencer();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) != 0) begin
                send_tr(rnd_tr(ACT_TICK), 0);
            end
            step_tr(1'($urandom_range(0, 2) == 0), 0);
        end
    endtask

    task automatic random_traffic(input int count);
        int stop_at;
        int r;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                queue_command();
            end else if (r < 85) begin
                run_sequencer();
            end else begin
                repeat ($urandom_range(1, 3)) send_tr(rnd_tr(3'($urandom_range(0, 7))), 0);
            end
        end
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial begin
        int g;
        int holds_done;
        i_out_ready  = 1'b0;
        rx_idle_left = 0;
        holds_done   = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                i_out_ready <= 1'b0;
            end else if (rx_idle_left > 0) begin
                i_out_ready <= 1'b0;
                rx_idle_left--;
            end else if (hold_req > holds_done) begin
                holds_done++;
                rx_idle_left = LONG_HOLD - 1;
                i_out_ready <= 1'b0;
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    rx_idle_left = g - 1;
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_CLEAR_WAIT;
        i_cfg_data = '0;
        items_sent = 0;
        no_gaps    = 1'b0;
        hold_req   = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: unused actions, refusals, full queue, held slot, busy timeout
        send_tr(mk_tr(ACT_STEP, 1'b0, 6'd0, 1'b0, 8'h00), 0);
        send_tr(mk_tr(ACT_SPARE_A, 1'b1, 6'd63, 1'b1, 8'hFF), 0);
        send_tr(mk_tr(ACT_SPARE_B, 1'b0, 6'd21, 1'b0, 8'h55), 0);
        send_tr(mk_tr(ACT_LOAD, 1'b0, 6'd0, 1'b0, 8'h00), 0);
        send_tr(mk_tr(ACT_LOAD, 1'b1, 6'd42, 1'b1, 8'hFF), 0);
        send_tr(mk_tr(ACT_LOAD, 1'b0, 6'd0, 1'b0, 8'h01), 0);
        send_tr(mk_tr(ACT_COMMIT, 1'b0, 6'd0, 1'b0, 8'h00), 0);
        send_tr(mk_tr(ACT_MOVE, 1'b0, 6'd63, 1'b1, 8'h00), 0);
        send_tr(mk_tr(ACT_CLEAR, 1'b0, 6'd0, 1'b0, 8'h00), 0);
        send_tr(mk_tr(ACT_CLEAR, 1'b1, 6'd7, 1'b1, 8'h80), 0);
        send_tr(mk_tr(ACT_LOAD, 1'b0, 6'd0, 1'b0, 8'h5A), 0);
        step_tr(1'b0, 0);
        send_tr(mk_tr(ACT_MOVE, 1'b0, 6'd0, 1'b0, 8'h00), 0);
        step_tr(1'b0, 0);
        step_tr(1'b1, 0);
        send_tr(rnd_tr(ACT_TICK), 0);
        step_tr(1'b1, 0);
        step_tr(1'b0, 0);
        repeat (3) begin
            send_tr(rnd_tr(ACT_TICK), 0);
            step_tr(1'b0, 0);
        end
        send_tr(mk_tr(ACT_MOVE, 1'b0, 6'd0, 1'b0, 8'h00), 0);
        drain_sequencer();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                1: begin
                    write_regs(8'd0, 8'd0);
                    hold_req++;
                end
                2: begin
                    write_regs(8'd3, 8'd255);
                    // park in busy polling long enough for the tick count to saturate
                    send_tr(rnd_tr(ACT_CLEAR), 0);
                    step_tr(1'b0, 0);
                    step_tr(1'b0, 0);
                    repeat (262) send_tr(rnd_tr(ACT_TICK), 0);
                    step_tr(1'b1, 0);
                    step_tr(1'b1, 0);
                end
                3: begin
                    write_regs(8'd1, 8'd1);
                    no_gaps = 1'b1;
                end
                4: write_regs(8'($urandom_range(0, 12)), 8'($urandom_range(0, 255)));
                default: ;
            endcase
            random_traffic(RANDOM_PER_PHASE);
            drain_sequencer();
            no_gaps = 1'b0;
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
